FILE: design/tccc_pkg.sv
// Package for the text console cursor controller.
// Holds payload, plan and configuration types, command and register codes,
// and the console geometry constants. No dependencies.
`timescale 1ns / 1ps

package tccc_pkg;

   localparam logic [7:0] COL_ORIGIN = 8'd0;
   localparam logic [6:0] ROW_ORIGIN = 7'd0;
   localparam logic [7:0] LAST_COL   = 8'd127;
   localparam logic [6:0] LAST_ROW   = 7'd63;
   localparam logic [4:0] TILE_W     = 5'd8;
   localparam logic [5:0] TILE_H     = 6'd16;
   localparam logic [7:0] TAB_STEP   = 8'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

   localparam logic [7:0]  RST_PADDING   = 8'd10;
   localparam logic [23:0] RST_BG_COLOR  = 24'h000000;
   localparam logic [23:0] RST_CUR_COLOR = 24'hFFFFFF;
   localparam logic [23:0] RST_CLR_COLOR = 24'h000000;

   typedef enum logic [1:0] {
      CMD_FILL  = 2'd0,
      CMD_GLYPH = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_PADDING   = 2'd0,
      REG_BG_COLOR  = 2'd1,
      REG_CUR_COLOR = 2'd2,
      REG_CLR_COLOR = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_FILL_BG  = 2'd0,
      OP_FILL_CUR = 2'd1,
      OP_GLYPH    = 2'd2,
      OP_CLEAR    = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic [7:0]  char_code;
      logic [23:0] glyph_color;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [7:0]  glyph_code;
      logic [23:0] paint_color;
      logic        last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  col;
      logic [6:0]  row;
   } op_type;

   typedef struct packed {
      op_type [2:0] ops;
      logic [1:0]   count;
      logic [7:0]   char_code;
      logic [23:0]  glyph_color;
   } plan_type;

   typedef struct packed {
      logic [7:0]  padding;
      logic [23:0] bg_color;
      logic [23:0] cur_color;
      logic [23:0] clr_color;
   } cfg_type;

endpackage

FILE: design/tccc_front.sv
// Front end: accepts characters, keeps the cursor and turns each character
// into a plan of up to three drawing operations. Depends on tccc_pkg.
`timescale 1ns / 1ps

module tccc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tccc_pkg::req_payload_type req_payload,
   input  logic                      queue_full,
   output logic                      push_valid,
   output tccc_pkg::plan_type        push_plan
);

   logic [7:0] cursor_col_ff;
   logic [7:0] cursor_col_in;
   logic [6:0] cursor_row_ff;
   logic [6:0] cursor_row_in;
   logic       accept;
   logic [6:0] row_inc;
   logic       row_over;
   logic [8:0] tab_sum;
   logic [7:0] prev_col;
   logic [7:0] next_col;
   tccc_pkg::plan_type plan;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign row_inc   = cursor_row_ff + 7'd1;
   assign row_over  = row_inc > tccc_pkg::LAST_ROW;
   assign tab_sum   = {1'b0, cursor_col_ff} + {1'b0, tccc_pkg::TAB_STEP};
   assign prev_col  = cursor_col_ff - 8'd1;
   assign next_col  = cursor_col_ff + 8'd1;

   always_comb begin
      plan             = '0;
      plan.char_code   = req_payload.char_code;
      plan.glyph_color = req_payload.glyph_color;
      cursor_col_in    = cursor_col_ff;
      cursor_row_in    = cursor_row_ff;
      case (req_payload.char_code)
         tccc_pkg::CHAR_NEWLINE: begin
            plan.ops[0] = '{tccc_pkg::OP_FILL_BG, cursor_col_ff, cursor_row_ff};
            cursor_col_in = tccc_pkg::COL_ORIGIN;
            if (row_over) begin
               plan.ops[1] = '{tccc_pkg::OP_CLEAR, 8'd0, 7'd0};
               plan.ops[2] = '{tccc_pkg::OP_FILL_CUR, tccc_pkg::COL_ORIGIN,
                               tccc_pkg::ROW_ORIGIN};
               plan.count = 2'd3;
               cursor_row_in = tccc_pkg::ROW_ORIGIN;
            end else begin
               plan.ops[1] = '{tccc_pkg::OP_FILL_CUR, tccc_pkg::COL_ORIGIN, row_inc};
               plan.count = 2'd2;
               cursor_row_in = row_inc;
            end
         end
         tccc_pkg::CHAR_BACKSPACE: begin
            if (cursor_col_ff > tccc_pkg::COL_ORIGIN) begin
               plan.ops[0] = '{tccc_pkg::OP_FILL_BG, cursor_col_ff, cursor_row_ff};
               plan.ops[1] = '{tccc_pkg::OP_FILL_BG, prev_col, cursor_row_ff};
               plan.ops[2] = '{tccc_pkg::OP_FILL_CUR, prev_col, cursor_row_ff};
               plan.count = 2'd3;
               cursor_col_in = prev_col;
            end
         end
         tccc_pkg::CHAR_TAB: begin
            if (tab_sum < {1'b0, tccc_pkg::LAST_COL}) begin
               cursor_col_in = tab_sum[7:0];
            end
         end
         default: begin
            if (cursor_col_ff > tccc_pkg::LAST_COL) begin
               if (row_over) begin
                  plan.ops[0] = '{tccc_pkg::OP_CLEAR, 8'd0, 7'd0};
                  plan.ops[1] = '{tccc_pkg::OP_FILL_CUR, tccc_pkg::COL_ORIGIN + 8'd1,
                                  tccc_pkg::ROW_ORIGIN};
                  plan.ops[2] = '{tccc_pkg::OP_GLYPH, tccc_pkg::COL_ORIGIN,
                                  tccc_pkg::ROW_ORIGIN};
                  plan.count = 2'd3;
                  cursor_row_in = tccc_pkg::ROW_ORIGIN;
               end else begin
                  plan.ops[0] = '{tccc_pkg::OP_FILL_CUR, tccc_pkg::COL_ORIGIN + 8'd1,
                                  row_inc};
                  plan.ops[1] = '{tccc_pkg::OP_GLYPH, tccc_pkg::COL_ORIGIN, row_inc};
                  plan.count = 2'd2;
                  cursor_row_in = row_inc;
               end
               cursor_col_in = tccc_pkg::COL_ORIGIN + 8'd1;
            end else begin
               plan.ops[0] = '{tccc_pkg::OP_FILL_CUR, next_col, cursor_row_ff};
               plan.ops[1] = '{tccc_pkg::OP_GLYPH, cursor_col_ff, cursor_row_ff};
               plan.count = 2'd2;
               cursor_col_in = next_col;
            end
         end
      endcase
   end

   assign push_valid = accept && (plan.count != 2'd0);
   assign push_plan  = plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= tccc_pkg::COL_ORIGIN;
         cursor_row_ff <= tccc_pkg::ROW_ORIGIN;
      end else if (accept) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

`ifndef SYNTHESIS
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_row_ff <= tccc_pkg::LAST_ROW)
      else $error("cursor row past last row");
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("plan pushed into full queue");
   a_tab_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.char_code == tccc_pkg::CHAR_TAB) |-> !push_valid)
      else $error("tab produced drawing operations");
`endif

endmodule

FILE: design/tccc_queue.sv
// Short plan queue between the front and back ends.
// Two entries, registers only. Depends on tccc_pkg.
`timescale 1ns / 1ps

module tccc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  tccc_pkg::plan_type push_plan,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output tccc_pkg::plan_type pop_plan
);

   tccc_pkg::plan_type entry_ff [tccc_pkg::QUEUE_DEPTH];
   logic [tccc_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [tccc_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [tccc_pkg::QPTR_W:0]   count_ff;
   logic [tccc_pkg::QPTR_W:0]   count_in;
   logic do_pop;

   assign full      = count_ff == (tccc_pkg::QPTR_W + 1)'(tccc_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign do_pop    = pop && pop_valid;
   assign pop_plan  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/tccc_back.sv
// Back end: walks the operations of each queued plan and issues one drawing
// command per cycle into the output register while the receiver does not stall. Depends on tccc_pkg.
`timescale 1ns / 1ps

module tccc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tccc_pkg::cfg_type         cfg,
   input  logic                      pop_valid,
   input  tccc_pkg::plan_type        pop_plan,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tccc_pkg::rsp_payload_type rsp_payload
);

   logic [1:0]  op_idx_ff;
   logic [1:0]  op_idx_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   tccc_pkg::rsp_payload_type rsp_payload_ff;
   tccc_pkg::rsp_payload_type rsp_payload_in;
   logic        advance;
   logic        take;
   logic        last_op;
   tccc_pkg::op_type op_cur;
   logic [15:0] x_wide;
   logic [15:0] y_wide;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign take    = advance && pop_valid;
   assign op_cur  = pop_plan.ops[op_idx_ff];
   assign last_op = op_idx_ff == (pop_plan.count - 2'd1);
   assign pop     = take && last_op;

   assign x_wide = 16'(op_cur.col) * 16'(tccc_pkg::TILE_W) + 16'(cfg.padding);
   assign y_wide = 16'(op_cur.row) * 16'(tccc_pkg::TILE_H) + 16'(cfg.padding);

   always_comb begin
      rsp_payload_in             = '0;
      rsp_payload_in.pixel_x     = x_wide[10:0];
      rsp_payload_in.pixel_y     = y_wide[10:0];
      rsp_payload_in.last_of_run = last_op;
      case (op_cur.kind)
         tccc_pkg::OP_FILL_BG: begin
            rsp_payload_in.command     = tccc_pkg::CMD_FILL;
            rsp_payload_in.paint_color = cfg.bg_color;
         end
         tccc_pkg::OP_FILL_CUR: begin
            rsp_payload_in.command     = tccc_pkg::CMD_FILL;
            rsp_payload_in.paint_color = cfg.cur_color;
         end
         tccc_pkg::OP_GLYPH: begin
            rsp_payload_in.command     = tccc_pkg::CMD_GLYPH;
            rsp_payload_in.glyph_code  = pop_plan.char_code;
            rsp_payload_in.paint_color = pop_plan.glyph_color;
         end
         default: begin
            rsp_payload_in.command     = tccc_pkg::CMD_CLEAR;
            rsp_payload_in.pixel_x     = '0;
            rsp_payload_in.pixel_y     = '0;
            rsp_payload_in.paint_color = cfg.clr_color;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = advance ? pop_valid : rsp_valid_ff;
      op_idx_in    = op_idx_ff;
      if (take) begin
         op_idx_in = last_op ? 2'd0 : op_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         op_idx_ff    <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         op_idx_ff    <= op_idx_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_idx_in_plan: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (op_idx_ff < pop_plan.count))
      else $error("operation index past plan length");
   a_plan_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (pop_plan.count != 2'd0))
      else $error("empty plan in queue");
   a_clear_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.command == tccc_pkg::CMD_CLEAR)
         |-> !rsp_payload_ff.last_of_run)
      else $error("clear command closed a run");
`endif

endmodule

FILE: design/text_console_cursor_controller_unit.sv
// An accepted character's plan is written into the plan queue, and its first command is then
// registered in the back end's output register, from which the receiver takes it.
// Throughput: a new character each cycle while the queue has room; commands leave one per
// cycle through the back end's single output register while the receiver does not stall.
// Tab and backspace at the origin column emit nothing and push no plan into the queue.
// Reset (synchronous) homes the cursor, empties the plan queue and output register,
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module text_console_cursor_controller_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tccc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tccc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wen,
   input  logic [1:0]                csr_index,
   input  logic [23:0]               csr_wdata
);

   tccc_pkg::cfg_type  cfg_ff;
   tccc_pkg::cfg_type  cfg_in;
   tccc_pkg::plan_type push_plan;
   tccc_pkg::plan_type pop_plan;
   logic               push_valid;
   logic               queue_full;
   logic               pop_valid;
   logic               pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            tccc_pkg::REG_PADDING:   cfg_in.padding   = csr_wdata[7:0];
            tccc_pkg::REG_BG_COLOR:  cfg_in.bg_color  = csr_wdata;
            tccc_pkg::REG_CUR_COLOR: cfg_in.cur_color = csr_wdata;
            tccc_pkg::REG_CLR_COLOR: cfg_in.clr_color = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.padding   <= tccc_pkg::RST_PADDING;
         cfg_ff.bg_color  <= tccc_pkg::RST_BG_COLOR;
         cfg_ff.cur_color <= tccc_pkg::RST_CUR_COLOR;
         cfg_ff.clr_color <= tccc_pkg::RST_CLR_COLOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tccc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_plan   (push_plan)
   );

   tccc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_plan  (push_plan),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_plan   (pop_plan)
   );

   tccc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_plan    (pop_plan),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/text_console_cursor_controller_unit_tb.sv
// Testbench for text_console_cursor_controller_unit. It sends characters and
// register writes, predicts every drawing command and checks them in order.
// Depends on tccc_pkg and the unit itself.
`timescale 1ns / 1ps

module text_console_cursor_controller_unit_tb;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int RANDOM_ITEMS    = 50;
   localparam int IDLE_PERCENT    = 17;
   localparam int MAX_PRINTED     = 40;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   tccc_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   tccc_pkg::rsp_payload_type rsp_payload;
   logic                      csr_wen     = 1'b0;
   logic [1:0]                csr_index   = '0;
   logic [23:0]               csr_wdata   = '0;

   tccc_pkg::cfg_type         console_cfg;
   logic [7:0]                cursor_col;
   logic [6:0]                cursor_row;
   tccc_pkg::rsp_payload_type expected_draws[$];
   tccc_pkg::rsp_payload_type run_cmds[3];
   int                        run_len;

   int error_count       = 0;
   int cycle_count       = 0;
   int sent_items        = 0;
   bit send_gaps_on      = 1'b1;
   bit rsp_gaps_on       = 1'b1;
   int hold_off_requests = 0;
   int hold_off_served   = 0;
   int hold_off_left     = 0;

   text_console_cursor_controller_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL text_console_cursor_controller_unit");
         $finish;
      end
   end

   // Receiver side: a requested hold-off wins over random stalls.
   always @(posedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic emit_draw(input tccc_pkg::cmd_type cmd, input int col, input int row,
                            input logic [7:0] glyph, input logic [23:0] color);
      tccc_pkg::rsp_payload_type draw;
      int px;
      int py;
      px = col * int'(tccc_pkg::TILE_W) + int'(console_cfg.padding);
      py = row * int'(tccc_pkg::TILE_H) + int'(console_cfg.padding);
      draw.command     = cmd;
      draw.pixel_x     = (cmd == tccc_pkg::CMD_CLEAR) ? 11'd0 : px[10:0];
      draw.pixel_y     = (cmd == tccc_pkg::CMD_CLEAR) ? 11'd0 : py[10:0];
      draw.glyph_code  = glyph;
      draw.paint_color = color;
      draw.last_of_run = 1'b0;
      run_cmds[run_len] = draw;
      run_len++;
   endtask

   task automatic advance_line();
      cursor_row = cursor_row + 7'd1;
      cursor_col = tccc_pkg::COL_ORIGIN;
      if (cursor_row > tccc_pkg::LAST_ROW) begin
         cursor_row = tccc_pkg::ROW_ORIGIN;
         emit_draw(tccc_pkg::CMD_CLEAR, 0, 0, 8'd0, console_cfg.clr_color);
      end
   endtask

   task automatic plan_drawing(input tccc_pkg::req_payload_type item);
      run_len = 0;
      if (item.char_code == tccc_pkg::CHAR_NEWLINE) begin
         emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col), int'(cursor_row), 8'd0,
                   console_cfg.bg_color);
         advance_line();
         emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col), int'(cursor_row), 8'd0,
                   console_cfg.cur_color);
      end else if (item.char_code == tccc_pkg::CHAR_BACKSPACE) begin
         if (cursor_col > tccc_pkg::COL_ORIGIN) begin
            emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col), int'(cursor_row), 8'd0,
                      console_cfg.bg_color);
            cursor_col = cursor_col - 8'd1;
            emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col), int'(cursor_row), 8'd0,
                      console_cfg.bg_color);
            emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col), int'(cursor_row), 8'd0,
                      console_cfg.cur_color);
         end
      end else if (item.char_code == tccc_pkg::CHAR_TAB) begin
         if (int'(cursor_col) + int'(tccc_pkg::TAB_STEP) < int'(tccc_pkg::LAST_COL))
            cursor_col = cursor_col + tccc_pkg::TAB_STEP;
      end else begin
         if (cursor_col > tccc_pkg::LAST_COL)
            advance_line();
         emit_draw(tccc_pkg::CMD_FILL, int'(cursor_col) + 1, int'(cursor_row), 8'd0,
                   console_cfg.cur_color);
         emit_draw(tccc_pkg::CMD_GLYPH, int'(cursor_col), int'(cursor_row), item.char_code,
                   item.glyph_color);
         cursor_col = cursor_col + 8'd1;
      end
      if (run_len > 0)
         run_cmds[run_len - 1].last_of_run = 1'b1;
      for (int i = 0; i < run_len; i++)
         expected_draws.push_back(run_cmds[i]);
   endtask

   task automatic apply_csr(input logic [1:0] index, input logic [23:0] data);
      case (index)
         tccc_pkg::REG_PADDING:   console_cfg.padding   = data[7:0];
         tccc_pkg::REG_BG_COLOR:  console_cfg.bg_color  = data;
         tccc_pkg::REG_CUR_COLOR: console_cfg.cur_color = data;
         tccc_pkg::REG_CLR_COLOR: console_cfg.clr_color = data;
         default: ;
      endcase
   endtask

   task automatic check_command(input tccc_pkg::rsp_payload_type got);
      tccc_pkg::rsp_payload_type want;
      if (expected_draws.size() == 0) begin
         report_mismatch("command with none expected", 64'(got), 64'd0);
         return;
      end
      want = expected_draws.pop_front();
      if (got.command != want.command)
         report_mismatch("command", 64'(got.command), 64'(want.command));
      if (got.pixel_x != want.pixel_x)
         report_mismatch("pixel_x", 64'(got.pixel_x), 64'(want.pixel_x));
      if (got.pixel_y != want.pixel_y)
         report_mismatch("pixel_y", 64'(got.pixel_y), 64'(want.pixel_y));
      if (got.glyph_code != want.glyph_code)
         report_mismatch("glyph_code", 64'(got.glyph_code), 64'(want.glyph_code));
      if (got.paint_color != want.paint_color)
         report_mismatch("paint_color", 64'(got.paint_color), 64'(want.paint_color));
      if (got.last_of_run != want.last_of_run)
         report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         console_cfg = '{tccc_pkg::RST_PADDING, tccc_pkg::RST_BG_COLOR,
                         tccc_pkg::RST_CUR_COLOR, tccc_pkg::RST_CLR_COLOR};
         cursor_col = tccc_pkg::COL_ORIGIN;
         cursor_row = tccc_pkg::ROW_ORIGIN;
         expected_draws.delete();
      end else begin
         if (csr_wen)
            apply_csr(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            plan_drawing(req_payload);
         if (rsp_valid && !rsp_stall)
            check_command(rsp_payload);
      end
   end

   function automatic logic [23:0] random_color();
      return 24'($urandom());
   endfunction

   function automatic logic [23:0] random_reg24();
      case ($urandom_range(3))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] random_printable();
      logic [7:0] code;
      do begin
         code = 8'($urandom_range(255));
      end while (code == tccc_pkg::CHAR_BACKSPACE || code == tccc_pkg::CHAR_TAB ||
                 code == tccc_pkg::CHAR_NEWLINE);
      return code;
   endfunction

   task automatic send_char(input logic [7:0] code, input logic [23:0] color);
      while (send_gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{char_code: code, glyph_color: color};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_items++;
   endtask

   task automatic send_printable();
      send_char(random_printable(), random_color());
   endtask

   task automatic send_control(input logic [7:0] code);
      send_char(code, random_color());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_draws.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_console(input logic [23:0] pad, input logic [23:0] bg,
                                  input logic [23:0] cur, input logic [23:0] clr);
      wait_drained();
      csr_wen <= 1'b1;
      csr_index <= tccc_pkg::REG_PADDING;
      csr_wdata <= pad;
      @(posedge clock);
      csr_index <= tccc_pkg::REG_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_index <= tccc_pkg::REG_CUR_COLOR;
      csr_wdata <= cur;
      @(posedge clock);
      csr_index <= tccc_pkg::REG_CLR_COLOR;
      csr_wdata <= clr;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic program_random_console();
      logic [23:0] pad;
      pad = 24'($urandom());
      case ($urandom_range(3))
         0: pad[7:0] = 8'h00;
         1: pad[7:0] = 8'hFF;
         default: ;
      endcase
      program_console(pad, random_reg24(), random_reg24(), random_reg24());
   endtask

   // Starts from the origin column: tab up to the line end, then print past it.
   task automatic fill_line_to_wrap();
      repeat (int'(tccc_pkg::LAST_COL) / int'(tccc_pkg::TAB_STEP))
         send_control(tccc_pkg::CHAR_TAB);
      send_control(tccc_pkg::CHAR_TAB);
      repeat (4) send_printable();
      send_control(tccc_pkg::CHAR_BACKSPACE);
      send_printable();
      send_printable();
   endtask

   task automatic test_control_characters();
      send_char(8'h41, 24'h000000);
      send_control(tccc_pkg::CHAR_BACKSPACE);
      send_control(tccc_pkg::CHAR_BACKSPACE);
      send_control(tccc_pkg::CHAR_TAB);
      send_char(8'h00, 24'hFFFFFF);
      send_char(8'hFF, 24'h5A5A5A);
      send_control(tccc_pkg::CHAR_NEWLINE);
      send_char(8'd11, 24'hA5A5A5);
      send_char(8'd7, random_color());
      send_control(tccc_pkg::CHAR_TAB);
      send_control(tccc_pkg::CHAR_BACKSPACE);
   endtask

   task automatic test_register_extremes();
      program_console(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
      send_printable();
      send_control(tccc_pkg::CHAR_NEWLINE);
      send_printable();
      send_control(tccc_pkg::CHAR_BACKSPACE);
      program_console(24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000);
      send_printable();
      send_control(tccc_pkg::CHAR_TAB);
      send_control(tccc_pkg::CHAR_BACKSPACE);
      send_control(tccc_pkg::CHAR_NEWLINE);
   endtask

   task automatic test_line_wrap();
      send_gaps_on = 1'b0;
      rsp_gaps_on <= 1'b0;
      send_control(tccc_pkg::CHAR_NEWLINE);
      fill_line_to_wrap();
      send_gaps_on = 1'b1;
      rsp_gaps_on <= 1'b1;
   endtask

   task automatic test_screen_clear();
      program_random_console();
      repeat (int'(tccc_pkg::LAST_ROW) - int'(cursor_row))
         send_control(tccc_pkg::CHAR_NEWLINE);
      send_control(tccc_pkg::CHAR_NEWLINE);
      wait_drained();
      repeat (int'(tccc_pkg::LAST_ROW) - int'(cursor_row))
         send_control(tccc_pkg::CHAR_NEWLINE);
      fill_line_to_wrap();
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_off_requests <= hold_off_requests + 1;
      repeat (24) begin
         if ($urandom_range(3) == 0)
            send_control(tccc_pkg::CHAR_NEWLINE);
         else
            send_printable();
      end
      wait_drained();
   endtask

   task automatic test_random_mix();
      int first_item;
      first_item = sent_items;
      program_random_console();
      while (sent_items - first_item < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2: repeat ($urandom_range(24, 1)) send_printable();
            3: repeat ($urandom_range(34, 1)) send_control(tccc_pkg::CHAR_TAB);
            4: repeat ($urandom_range(40, 1)) send_control(tccc_pkg::CHAR_NEWLINE);
            5: repeat ($urandom_range(8, 1)) send_control(tccc_pkg::CHAR_BACKSPACE);
            6: repeat ($urandom_range(8, 1))
                  send_char(8'($urandom_range(255)), random_color());
            7: begin
               send_control(tccc_pkg::CHAR_NEWLINE);
               fill_line_to_wrap();
            end
            8: program_random_console();
            default: wait_drained();
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_control_characters();
      test_register_extremes();
      test_line_wrap();
      test_screen_clear();
      test_backpressure();
      test_random_mix();
      wait_drained();
      if (error_count == 0)
         $display("PASS text_console_cursor_controller_unit");
      else
         $display("FAIL text_console_cursor_controller_unit");
      $finish;
   end

endmodule

FILE: text_console_cursor_controller_unit.f
design/tccc_pkg.sv
design/tccc_front.sv
design/tccc_queue.sv
design/tccc_back.sv
design/text_console_cursor_controller_unit.sv
tb/text_console_cursor_controller_unit_tb.sv
